[src/lztd_pkg.sv]
// ---------------------------------------------------------------------------
// lztd_pkg
// Shared types and constants for the LZ token history decoder.
// ---------------------------------------------------------------------------
package lztd_pkg;

  // request type codes
  localparam logic [2:0] REQ_LIT  = 3'd0;
  localparam logic [2:0] REQ_LEN  = 3'd1;
  localparam logic [2:0] REQ_EXT  = 3'd2;
  localparam logic [2:0] REQ_OFS  = 3'd3;
  localparam logic [2:0] REQ_CONT = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  localparam logic [7:0] LEN_ESCAPE      = 8'd250;
  localparam logic [7:0] EXT_MORE        = 8'hFF;
  localparam int         MIN_MATCH       = 4;
  localparam int         LOW_OFFSET_BITS = 8;
  localparam int         HIST_AW         = 16;

  // what the captured item does in the current token phase
  typedef enum logic [2:0] {
    K_LIT,
    K_LEN,
    K_EXT,
    K_OFS_OK,
    K_OFS_ERR,
    K_CONT,
    K_BAD
  } kind_t;

  typedef struct packed {
    logic cap;         // capture the accepted item
    logic exec_len;    // open a match with a length code
    logic exec_ext;    // add an extension byte
    logic start_copy;  // size the next burst of a copy
    logic resp;        // emit a literal or an error result
    logic rd;          // read one history byte
    logic wr;          // write it back and emit it
  } lztd_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  burst_empty;
    logic  burst_last;
    logic  out_free;
  } lztd_stat_t;

endpackage

[src/lztd_in_if.sv]
// ---------------------------------------------------------------------------
// lztd_in_if
// Token channel: valid/ready handshake with the token fields.
// ---------------------------------------------------------------------------
interface lztd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  item_byte;
  logic [15:0] match_offset;

  modport source (output valid, req_type, item_byte, match_offset, input ready);
  modport sink (input valid, req_type, item_byte, match_offset, output ready);
endinterface

[src/lztd_out_if.sv]
// ---------------------------------------------------------------------------
// lztd_out_if
// Result channel: valid/ready handshake with one decoded byte and its flags.
// ---------------------------------------------------------------------------
interface lztd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       more_pending;
  logic [1:0] status;

  modport source (output valid, out_byte, out_last, more_pending, status, input ready);
  modport sink (input valid, out_byte, out_last, more_pending, status, output ready);
endinterface

[src/lztd_datapath.sv]
// ---------------------------------------------------------------------------
// lztd_datapath
// History memory, match length and position registers, output register.
// ---------------------------------------------------------------------------
module lztd_datapath
  import lztd_pkg::*;
#(
  parameter int OFFSET_HIGH_BITS = 8,
  parameter int MAX_BURST        = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lztd_cmd_t   cmd,
  output lztd_stat_t  stat,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_item_byte,
  input  logic [15:0] in_match_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_more_pending,
  output logic [1:0]  out_status
);

  localparam int CW        = $clog2(MAX_BURST + 1);
  localparam int OFS_LIM_W = OFFSET_HIGH_BITS + LOW_OFFSET_BITS;
  localparam int HIST_DEPTH = 1 << HIST_AW;

  typedef enum logic [1:0] {PH_IDLE, PH_LEN, PH_EXT, PH_COPY} phase_t;

  logic [7:0]         hist_mem [HIST_DEPTH];

  logic [2:0]         req_r;
  logic [7:0]         ib_r;
  logic [15:0]        off_r;
  phase_t             phase_r;
  logic [HIST_AW-1:0] wp_r;
  logic [HIST_AW:0]   filled_r;
  logic [31:0]        pending_r;
  logic [15:0]        dist_r;
  logic [CW-1:0]      cnt_r;
  logic               more_r;
  logic [7:0]         rd_data_r;

  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_last_r;
  logic               out_more_r;
  logic [1:0]         out_status_r;

  logic               out_free;
  logic               ofs_bad;
  kind_t              kind;
  logic [CW-1:0]      burst_n;
  logic [32:0]        ext_sum;
  logic               mem_we;
  logic [7:0]         mem_wdata;
  logic               push;

  assign out_free = !out_valid_r || out_ready;
  assign ofs_bad  = ({1'b0, off_r} > filled_r) || ((off_r >> OFS_LIM_W) != 16'd0);

  always_comb begin
    kind = K_BAD;
    case (req_r)
      REQ_LIT:  if (phase_r == PH_IDLE) kind = K_LIT;
      REQ_LEN:  if (phase_r == PH_IDLE) kind = K_LEN;
      REQ_EXT:  if (phase_r == PH_EXT) kind = K_EXT;
      REQ_OFS:  if (phase_r == PH_LEN) kind = (off_r == 16'd0 || ofs_bad) ? K_OFS_ERR : K_OFS_OK;
      REQ_CONT: if (phase_r == PH_COPY) kind = K_CONT;
      default:  kind = K_BAD;
    endcase
  end

  assign burst_n = (pending_r < 32'(MAX_BURST)) ? pending_r[CW-1:0] : CW'(MAX_BURST);
  assign ext_sum = {1'b0, pending_r} + {25'd0, ib_r};

  assign stat.kind        = kind;
  assign stat.burst_empty = (pending_r == 32'd0);
  assign stat.burst_last  = (cnt_r == CW'(1));
  assign stat.out_free    = out_free;

  // history writes: a literal result or a copied byte
  assign mem_we    = (cmd.resp && kind == K_LIT) || cmd.wr;
  assign mem_wdata = cmd.wr ? rd_data_r : ib_r;
  assign push      = mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wp_r] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_data_r <= hist_mem[wp_r - dist_r];
    end
  end

  // item capture and copy bookkeeping without reset
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_req_type;
      ib_r  <= in_item_byte;
      off_r <= in_match_offset;
    end
    if (cmd.start_copy) begin
      cnt_r  <= burst_n;
      more_r <= (pending_r != 32'(burst_n));
      if (kind == K_OFS_OK) begin
        dist_r <= off_r;
      end
    end else if (cmd.wr) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      wp_r      <= '0;
      filled_r  <= '0;
      pending_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + HIST_AW'(1);
        if (!filled_r[HIST_AW]) begin
          filled_r <= filled_r + (HIST_AW+1)'(1);
        end
      end
      if (cmd.exec_len) begin
        pending_r <= 32'(ib_r) + 32'(MIN_MATCH);
        phase_r   <= (ib_r == LEN_ESCAPE) ? PH_EXT : PH_LEN;
      end
      if (cmd.exec_ext) begin
        pending_r <= ext_sum[32] ? 32'hFFFF_FFFF : ext_sum[31:0];
        if (ib_r != EXT_MORE) begin
          phase_r <= PH_LEN;
        end
      end
      if (cmd.start_copy) begin
        pending_r <= pending_r - 32'(burst_n);
        phase_r   <= (pending_r != 32'(burst_n)) ? PH_COPY : PH_IDLE;
      end
      if (cmd.resp && kind == K_OFS_ERR) begin
        pending_r <= '0;
        phase_r   <= PH_IDLE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp || cmd.wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      out_byte_r   <= rd_data_r;
      out_last_r   <= (cnt_r == CW'(1));
      out_more_r   <= more_r;
      out_status_r <= ST_OK;
    end else if (cmd.resp) begin
      out_last_r <= 1'b1;
      case (kind)
        K_LIT: begin
          out_byte_r   <= ib_r;
          out_more_r   <= 1'b0;
          out_status_r <= ST_OK;
        end
        K_OFS_ERR: begin
          out_byte_r   <= 8'd0;
          out_more_r   <= 1'b0;
          out_status_r <= (off_r == 16'd0) ? ST_ZERO : ST_RANGE;
        end
        default: begin
          out_byte_r   <= 8'd0;
          out_more_r   <= (phase_r == PH_COPY);
          out_status_r <= ST_ORDER;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last         = out_last_r;
  assign out_more_pending = out_more_r;
  assign out_status       = out_status_r;

endmodule

[src/lztd_ctrl.sv]
// ---------------------------------------------------------------------------
// lztd_ctrl
// Sequencer: takes one token, dispatches it and steps copies byte by byte.
// ---------------------------------------------------------------------------
module lztd_ctrl
  import lztd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lztd_stat_t stat,
  output lztd_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_RESP, S_CP_RD, S_CP_WR} state_t;

  state_t state_r;
  logic   in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= S_EXEC;
            in_ready_r <= 1'b0;
          end
        end
        S_EXEC: begin
          case (stat.kind)
            K_LEN, K_EXT: begin
              state_r    <= S_IDLE;
              in_ready_r <= 1'b1;
            end
            K_OFS_OK, K_CONT: begin
              if (stat.burst_empty) begin
                state_r    <= S_IDLE;
                in_ready_r <= 1'b1;
              end else begin
                state_r <= S_CP_RD;
              end
            end
            default: state_r <= S_RESP;
          endcase
        end
        S_RESP: begin
          if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        S_CP_RD: state_r <= S_CP_WR;
        S_CP_WR: begin
          if (stat.out_free) begin
            if (stat.burst_last) begin
              state_r    <= S_IDLE;
              in_ready_r <= 1'b1;
            end else begin
              state_r <= S_CP_RD;
            end
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.cap        = (state_r == S_IDLE) && in_valid && in_ready_r;
    cmd.exec_len   = (state_r == S_EXEC) && (stat.kind == K_LEN);
    cmd.exec_ext   = (state_r == S_EXEC) && (stat.kind == K_EXT);
    cmd.start_copy = (state_r == S_EXEC) && (stat.kind == K_OFS_OK || stat.kind == K_CONT);
    cmd.resp       = (state_r == S_RESP) && stat.out_free;
    cmd.rd         = (state_r == S_CP_RD);
    cmd.wr         = (state_r == S_CP_WR) && stat.out_free;
  end

  assign in_ready = in_ready_r;

endmodule

[src/lz_token_history_decoder.sv]
// ---------------------------------------------------------------------------
// lz_token_history_decoder
// Rebuilds a byte stream from separated LZ tokens over a 64 KiB history.
// ---------------------------------------------------------------------------
// usage:
//   in_chan  : one token per transfer (literal, length code, extension byte,
//              match offset or continue), valid/ready
//   out_chan : one result per transfer: a rebuilt byte or an error status,
//              out_last marks the last result of a token
//   one token is in flight at a time; ready drops after a transfer and
//   rises again once the token has finished
//   literal and error tokens give one result, registered from the response
//   state; length and extension tokens give no result
//   offset and continue tokens copy bytes from the history, up to
//   MAX_BURST bytes per token; each byte is a read then a write on the
//   single-port history memory, which sets the copy rate
//   results sit in an output register; a stalled receiver holds the
//   sequencer at the next result, nothing is dropped
//   reset clears position, fill count, length and phase; the history memory
//   is not cleared and needs no clearing pass, offsets never reach beyond
//   what has been written
// ---------------------------------------------------------------------------
module lz_token_history_decoder
  import lztd_pkg::*;
#(
  parameter int OFFSET_HIGH_BITS = 8,
  parameter int MAX_BURST        = 64
) (
  input logic              clk,
  input logic              rst_n,
  lztd_in_if.sink          in_chan,
  lztd_out_if.source       out_chan
);

  lztd_cmd_t  cmd;
  lztd_stat_t stat;

  lztd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lztd_datapath #(
    .OFFSET_HIGH_BITS (OFFSET_HIGH_BITS),
    .MAX_BURST        (MAX_BURST)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_chan.req_type),
    .in_item_byte     (in_chan.item_byte),
    .in_match_offset  (in_chan.match_offset),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_byte         (out_chan.out_byte),
    .out_last         (out_chan.out_last),
    .out_more_pending (out_chan.more_pending),
    .out_status       (out_chan.status)
  );

endmodule
